// ===== rtl/rne_pkg.sv =====
// shared types, letter codes and the subtractive table of the roman numeral encoder
package rne_pkg;

  localparam int unsigned ValueW = 12;
  localparam int unsigned AsciiW = 7;
  localparam int unsigned TabDepth = 13;
  localparam int unsigned IdxW = $clog2(TabDepth);

  typedef logic [ValueW-1:0] value_t;
  typedef logic [AsciiW-1:0] ascii_t;
  typedef logic [IdxW-1:0]   idx_t;

  localparam value_t MaxValue = value_t'(3999);
  localparam idx_t   LastIdx  = idx_t'(TabDepth - 1);

  localparam ascii_t ChNone = ascii_t'(8'h00);
  localparam ascii_t ChI    = ascii_t'(8'h49);
  localparam ascii_t ChV    = ascii_t'(8'h56);
  localparam ascii_t ChX    = ascii_t'(8'h58);
  localparam ascii_t ChL    = ascii_t'(8'h4C);
  localparam ascii_t ChC    = ascii_t'(8'h43);
  localparam ascii_t ChD    = ascii_t'(8'h44);
  localparam ascii_t ChM    = ascii_t'(8'h4D);

  typedef struct packed {
    value_t amount;
    ascii_t first;
    ascii_t second;
    logic   pair;
  } tab_entry_t;

  // result of one compare and subtract step
  typedef struct packed {
    logic   ge;
    value_t diff;
    ascii_t first;
    ascii_t second;
    logic   pair;
  } rne_step_t;

  // rows in descending order, subtractive pairs carry a second letter
  function automatic tab_entry_t tab_entry(idx_t idx);
    tab_entry_t e;
    e = '{amount: value_t'(1), first: ChI, second: ChNone, pair: 1'b0};
    unique case (idx)
      idx_t'(0):  e = '{amount: value_t'(1000), first: ChM, second: ChNone, pair: 1'b0};
      idx_t'(1):  e = '{amount: value_t'(900),  first: ChC, second: ChM,    pair: 1'b1};
      idx_t'(2):  e = '{amount: value_t'(500),  first: ChD, second: ChNone, pair: 1'b0};
      idx_t'(3):  e = '{amount: value_t'(400),  first: ChC, second: ChD,    pair: 1'b1};
      idx_t'(4):  e = '{amount: value_t'(100),  first: ChC, second: ChNone, pair: 1'b0};
      idx_t'(5):  e = '{amount: value_t'(90),   first: ChX, second: ChC,    pair: 1'b1};
      idx_t'(6):  e = '{amount: value_t'(50),   first: ChL, second: ChNone, pair: 1'b0};
      idx_t'(7):  e = '{amount: value_t'(40),   first: ChX, second: ChL,    pair: 1'b1};
      idx_t'(8):  e = '{amount: value_t'(10),   first: ChX, second: ChNone, pair: 1'b0};
      idx_t'(9):  e = '{amount: value_t'(9),    first: ChI, second: ChX,    pair: 1'b1};
      idx_t'(10): e = '{amount: value_t'(5),    first: ChV, second: ChNone, pair: 1'b0};
      idx_t'(11): e = '{amount: value_t'(4),    first: ChI, second: ChV,    pair: 1'b1};
      default:    e = '{amount: value_t'(1),    first: ChI, second: ChNone, pair: 1'b0};
    endcase
    return e;
  endfunction

endpackage

// ===== rtl/rne_step.sv =====
// shared compare and subtract unit against one row of the numeral table
module rne_step (
  input  rne_pkg::value_t   rem_i,
  input  rne_pkg::idx_t     idx_i,
  output rne_pkg::rne_step_t step_o
);
  import rne_pkg::*;

  tab_entry_t entry;

  assign entry         = tab_entry(idx_i);
  assign step_o.ge     = (rem_i >= entry.amount);
  assign step_o.diff   = rem_i - entry.amount;
  assign step_o.first  = entry.first;
  assign step_o.second = entry.second;
  assign step_o.pair   = entry.pair;

endmodule

// ===== rtl/roman_numeral_encoder.sv =====
// roman numeral encoder top level: sequencer, remainder register and output word register
//
//   channel  direction  handshake              payload
//   in       sink       in_valid_i/in_ready_o  value_i
//   out      source     out_valid_o/out_ready_i letter_o, no_letter_o, out_of_range_o,
//                                               last_letter_o
//
// after a word is accepted, each sequencer step emits one letter or passes over one
// table row, so a word has at most 15 letters and 12 rows passed over; zero and out of
// range words give one empty word. the single compare/subtract unit sets the pace.
// reset clears the sequencer and output valid. a stalled output word holds the sequencer
// before a letter; in_ready_o is high only while idle, even with an output word waiting.
module roman_numeral_encoder (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rne_pkg::value_t value_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rne_pkg::ascii_t letter_o,
  output logic            no_letter_o,
  output logic            out_of_range_o,
  output logic            last_letter_o
);
  import rne_pkg::*;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StRun  = 3'b010,
    StPair = 3'b100
  } state_e;

  state_e    state_q, state_d;
  value_t    rem_q, rem_d;
  idx_t      idx_q, idx_d;
  logic      err_q, err_d;
  logic      zero_q, zero_d;
  rne_step_t step;

  logic      out_valid_q, out_valid_d;
  ascii_t    letter_q, letter_d;
  logic      none_q, none_d;
  logic      oor_q, oor_d;
  logic      last_q, last_d;
  logic      slot_free;
  logic      emit;

  rne_step u_step (
    .rem_i (rem_q),
    .idx_i (idx_q),
    .step_o(step)
  );

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d  = state_q;
    rem_d    = rem_q;
    idx_d    = idx_q;
    err_d    = err_q;
    zero_d   = zero_q;
    emit     = 1'b0;
    letter_d = letter_q;
    none_d   = none_q;
    oor_d    = oor_q;
    last_d   = last_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          rem_d   = value_i;
          idx_d   = '0;
          err_d   = (value_i > MaxValue);
          zero_d  = (value_i == '0);
          state_d = StRun;
        end
      end
      StRun: begin
        if (err_q || zero_q) begin
          if (slot_free) begin
            emit     = 1'b1;
            letter_d = ChNone;
            none_d   = 1'b1;
            oor_d    = err_q;
            last_d   = 1'b1;
            state_d  = StIdle;
          end
        end else if (step.ge) begin
          if (slot_free) begin
            emit     = 1'b1;
            letter_d = step.first;
            none_d   = 1'b0;
            oor_d    = 1'b0;
            last_d   = (step.diff == '0) && !step.pair;
            rem_d    = step.diff;
            if (step.pair) begin
              state_d = StPair;
            end else if (step.diff == '0) begin
              state_d = StIdle;
            end
          end
        end else begin
          // row too large for the remainder, move to the next one
          idx_d = idx_q + idx_t'(1);
        end
      end
      StPair: begin
        if (slot_free) begin
          emit     = 1'b1;
          letter_d = step.second;
          none_d   = 1'b0;
          oor_d    = 1'b0;
          last_d   = (rem_q == '0);
          state_d  = (rem_q == '0) ? StIdle : StRun;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      err_q       <= 1'b0;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      err_q       <= err_d;
      zero_q      <= zero_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    letter_q <= letter_d;
    none_q   <= none_d;
    oor_q    <= oor_d;
    last_q   <= last_d;
  end

  assign in_ready_o     = (state_q == StIdle);
  assign out_valid_o    = out_valid_q;
  assign letter_o       = letter_q;
  assign no_letter_o    = none_q;
  assign out_of_range_o = oor_q;
  assign last_letter_o  = last_q;

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("encoder ready right after taking a word");

  a_idx_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= LastIdx)
    else $error("table row index past the last row");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_letter_o |-> last_letter_o && (letter_o == ChNone))
    else $error("empty result not marked as last");

  a_oor_is_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |-> no_letter_o)
    else $error("out of range result carries a letter");
`endif

endmodule

// ===== tb/rne_checker.sv =====
// scoreboard of the roman numeral encoder: predicts letter words from accepted values and compares
`timescale 1ns / 100ps

module rne_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  rne_pkg::value_t value_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  rne_pkg::ascii_t letter_i,
  input  logic            no_letter_i,
  input  logic            out_of_range_i,
  input  logic            last_letter_i,
  output int              fails_o,
  output int              words_due_o
);
  import rne_pkg::*;

  typedef struct packed {
    ascii_t letter;
    logic   none;
    logic   err;
    logic   last;
  } numeral_word_t;

  numeral_word_t words_due[$];
  ascii_t        spelled[$];
  int            mismatches = 0;
  int            open_words = 0;

  assign fails_o     = mismatches;
  assign words_due_o = open_words;

  // one decimal digit in the letters of its decade
  task automatic add_digit(input int unsigned digit, input ascii_t one, input ascii_t five,
                           input ascii_t ten);
    int unsigned n;
    case (digit)
      4: begin
        spelled.push_back(one);
        spelled.push_back(five);
      end
      9: begin
        spelled.push_back(one);
        spelled.push_back(ten);
      end
      default: begin
        if (digit >= 5) spelled.push_back(five);
        for (n = digit % 5; n > 0; n--) spelled.push_back(one);
      end
    endcase
  endtask

  task automatic spell_numeral(input value_t v);
    int unsigned   num;
    int            i;
    numeral_word_t w;
    num = v;
    w.letter = ChNone;
    w.none   = 1'b1;
    w.last   = 1'b1;
    if (v > MaxValue) begin
      w.err = 1'b1;
      words_due.push_back(w);
    end else if (num == 0) begin
      w.err = 1'b0;
      words_due.push_back(w);
    end else begin
      spelled.delete();
      add_digit(num / 1000, ChM, ChNone, ChNone);
      add_digit((num / 100) % 10, ChC, ChD, ChM);
      add_digit((num / 10) % 10, ChX, ChL, ChC);
      add_digit(num % 10, ChI, ChV, ChX);
      for (i = 0; i < spelled.size(); i++) begin
        w.letter = spelled[i];
        w.none   = 1'b0;
        w.err    = 1'b0;
        w.last   = (i == spelled.size() - 1);
        words_due.push_back(w);
      end
    end
  endtask

  always @(posedge clk_i) begin
    numeral_word_t want;
    if (rst_ni) begin
      // compare first: a word leaving now never belongs to a value entering now
      if (out_valid_i && out_ready_i) begin
        if (words_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected word letter=%h none=%b err=%b last=%b", $realtime,
                     letter_i, no_letter_i, out_of_range_i, last_letter_i);
        end else begin
          want = words_due.pop_front();
          if (letter_i !== want.letter || no_letter_i !== want.none ||
              out_of_range_i !== want.err || last_letter_i !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch letter %h/%h none %b/%b err %b/%b last %b/%b (exp/act)",
                       $realtime, want.letter, letter_i, want.none, no_letter_i,
                       want.err, out_of_range_i, want.last, last_letter_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) spell_numeral(value_i);
      open_words = words_due.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
// top of the roman numeral encoder testbench: clock, reset, value and ready stimulus, verdict
`timescale 1ns / 100ps

module tb;
  import rne_pkg::*;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   in_valid_i = 1'b0;
  logic   out_ready_i = 1'b0;
  value_t value_i = '0;
  logic   in_ready_o;
  logic   out_valid_o;
  ascii_t letter_o;
  logic   no_letter_o;
  logic   out_of_range_o;
  logic   last_letter_o;
  int     fails;
  int     words_due;

  value_t corner_values [25];

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  roman_numeral_encoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .letter_o      (letter_o),
    .no_letter_o   (no_letter_o),
    .out_of_range_o(out_of_range_o),
    .last_letter_o (last_letter_o)
  );

  rne_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .value_i       (value_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .letter_i      (letter_o),
    .no_letter_i   (no_letter_o),
    .out_of_range_i(out_of_range_o),
    .last_letter_i (last_letter_o),
    .fails_o       (fails),
    .words_due_o   (words_due)
  );

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // value side
  initial begin
    int          i;
    int          gap;
    int          sel;
    int unsigned num;
    value_t      v;
    // zero, single digits, subtractive pairs, longest run, range edges, bit patterns
    corner_values = '{12'd0, 12'd1, 12'd2, 12'd3, 12'd4, 12'd5, 12'd6, 12'd7, 12'd8, 12'd9,
                      12'd14, 12'd40, 12'd49, 12'd90, 12'd400, 12'd444, 12'd900, 12'd999,
                      12'd1994, 12'd3888, 12'd3999, 12'd4000, 12'd4095, 12'd2730, 12'd1365};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (i = 0; i < 220; i++) begin
      if (i < 25) begin
        v = corner_values[i];
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 68) begin
          v = value_t'($urandom_range(1, 3999));
        end else if (sel < 78) begin
          v = value_t'($urandom_range(4000, 4095));
        end else if (sel < 82) begin
          v = '0;
        end else begin
          // long runs: thousands 0 to 3, other digits 8 or any of 3 to 9
          num = $urandom_range(0, 3) * 1000;
          num += ($urandom_range(0, 1) ? 8 : $urandom_range(3, 9)) * 100;
          num += ($urandom_range(0, 1) ? 8 : $urandom_range(3, 9)) * 10;
          num += $urandom_range(0, 1) ? 8 : $urandom_range(3, 9);
          v = value_t'(num);
        end
      end
      gap = ((i / 20) % 3 == 1) ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      value_i    <= v;
      do @(posedge clk_i); while (!in_ready_o);
    end
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (words_due != 0);
    repeat (40) @(posedge clk_i);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // word side, with one long hold-off so the encoder backs up onto its input
  initial begin
    int stall;
    int n;
    n = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (n == 60) stall = 400;
      else stall = ((n / 25) % 3 == 2) ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      n++;
    end
  end

endmodule
